/* rtl/nbsk_pkg.sv */
// ----------------------------------------------------------------------------
// nbsk_pkg
// Shared constants and types for the NKRO bitmap to six-key report block.
// ----------------------------------------------------------------------------
package nbsk_pkg;

   localparam int BITMAP_BYTES = 32;
   localparam int KEY_SLOTS    = 6;
   localparam int SLOT_FIELDS  = 6;

   // byte counter has to hold BITMAP_BYTES itself
   localparam int POS_W      = $clog2(BITMAP_BYTES + 1);
   localparam int CNT_W      = $clog2(KEY_SLOTS + 1);
   localparam int SLOT_IDX_W = $clog2(SLOT_FIELDS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ROLLOVER_CODE = 8'h01;

   // one classified bitmap byte
   typedef struct packed {
      logic [7:0]       bits;
      logic [POS_W-1:0] pos;
      logic [7:0]       mods;
      logic             last;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } enq_type;

   typedef struct packed {
      logic [7:0]                  mods;
      logic [SLOT_FIELDS-1:0][7:0] slots;
      logic                        rollover;
   } report_type;

endpackage

/* rtl/nbsk_front.sv */
// ----------------------------------------------------------------------------
// nbsk_front
// Accepts bitmap bytes, tracks the byte index and masks bits that never
// count as keys (usage 0, bytes past the bitmap).
// ----------------------------------------------------------------------------
module nbsk_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [7:0]          req_bitmap_byte,
   input  logic [7:0]          req_modifier_bits,
   input  logic                req_last_byte,
   input  logic                q_full,
   output nbsk_pkg::enq_type   enq
);

   logic [nbsk_pkg::POS_W-1:0] pos_ff;
   logic [nbsk_pkg::POS_W-1:0] pos_in;
   logic                       accept;
   logic                       in_range;
   logic [7:0]                 bits;

   assign full = q_full;

   always_comb begin
      accept   = push && !q_full;
      in_range = pos_ff < nbsk_pkg::POS_W'(nbsk_pkg::BITMAP_BYTES);
      bits     = in_range ? req_bitmap_byte : 8'h00;
      if (pos_ff == '0) begin
         bits[0] = 1'b0;
      end
      pos_in = pos_ff;
      if (accept) begin
         if (req_last_byte) begin
            pos_in = '0;
         end else if (in_range) begin
            pos_in = pos_ff + nbsk_pkg::POS_W'(1);
         end
      end
      enq.push       = accept;
      enq.entry.bits = bits;
      enq.entry.pos  = pos_ff;
      enq.entry.mods = req_modifier_bits;
      enq.entry.last = req_last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* rtl/nbsk_queue.sv */
// ----------------------------------------------------------------------------
// nbsk_queue
// Short FIFO between the front and the slot collector.
// ----------------------------------------------------------------------------
module nbsk_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  nbsk_pkg::enq_type    enq,
   output logic                 q_full,
   output logic                 deq_valid,
   output nbsk_pkg::entry_type  deq_entry,
   input  logic                 deq_pop
);

   nbsk_pkg::entry_type          mem_ff [nbsk_pkg::QUEUE_DEPTH];
   logic [nbsk_pkg::QPTR_W-1:0]  wr_ptr_ff;
   logic [nbsk_pkg::QPTR_W-1:0]  wr_ptr_in;
   logic [nbsk_pkg::QPTR_W-1:0]  rd_ptr_ff;
   logic [nbsk_pkg::QPTR_W-1:0]  rd_ptr_in;
   logic [nbsk_pkg::QCNT_W-1:0]  count_ff;
   logic [nbsk_pkg::QCNT_W-1:0]  count_in;
   logic                         do_pop;

   assign q_full    = count_ff == nbsk_pkg::QCNT_W'(nbsk_pkg::QUEUE_DEPTH);
   assign deq_valid = count_ff != '0;
   assign deq_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      do_pop    = deq_pop && deq_valid;
      wr_ptr_in = enq.push ? wr_ptr_ff + nbsk_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + nbsk_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (enq.push && !do_pop) begin
         count_in = count_ff + nbsk_pkg::QCNT_W'(1);
      end else if (!enq.push && do_pop) begin
         count_in = count_ff - nbsk_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq.push) begin
         mem_ff[wr_ptr_ff] <= enq.entry;
      end
   end

endmodule

/* rtl/nbsk_back.sv */
// ----------------------------------------------------------------------------
// nbsk_back
// Collects key usages into slots one byte per cycle (a last byte waits while
// an untaken report is held) and holds the finished report until it is taken.
// ----------------------------------------------------------------------------
module nbsk_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  deq_valid,
   input  nbsk_pkg::entry_type   deq_entry,
   output logic                  deq_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output nbsk_pkg::report_type  report
);

   logic [nbsk_pkg::CNT_W-1:0]                cnt_ff;
   logic [nbsk_pkg::CNT_W-1:0]                cnt_in;
   logic                                      ovf_ff;
   logic                                      ovf_in;
   logic [nbsk_pkg::SLOT_FIELDS-1:0][7:0]     slots_ff;
   logic [nbsk_pkg::SLOT_FIELDS-1:0][7:0]     slots_in;
   logic                                      out_valid_ff;
   nbsk_pkg::report_type                      report_ff;
   logic                                      can_out;

   // bits are walked in ascending order; at most eight narrow steps
   always_comb begin
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      slots_in = slots_ff;
      for (int b = 0; b < 8; b++) begin
         if (!ovf_in && deq_entry.bits[b]) begin
            if (cnt_in >= nbsk_pkg::CNT_W'(nbsk_pkg::KEY_SLOTS)) begin
               for (int i = 0; i < nbsk_pkg::KEY_SLOTS; i++) begin
                  slots_in[i] = nbsk_pkg::ROLLOVER_CODE;
               end
               ovf_in = 1'b1;
            end else begin
               slots_in[nbsk_pkg::SLOT_IDX_W'(cnt_in)] = 8'({deq_entry.pos, 3'(b)});
               cnt_in = cnt_in + nbsk_pkg::CNT_W'(1);
            end
         end
      end
   end

   assign can_out   = !out_valid_ff || rsp_pop;
   assign deq_pop   = deq_valid && (!deq_entry.last || can_out);
   assign rsp_empty = !out_valid_ff;
   assign report    = report_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         slots_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (deq_pop) begin
            if (deq_entry.last) begin
               cnt_ff       <= '0;
               ovf_ff       <= 1'b0;
               slots_ff     <= '0;
               out_valid_ff <= 1'b1;
            end else begin
               cnt_ff   <= cnt_in;
               ovf_ff   <= ovf_in;
               slots_ff <= slots_in;
               if (rsp_pop) begin
                  out_valid_ff <= 1'b0;
               end
            end
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (deq_pop && deq_entry.last) begin
         report_ff.mods     <= deq_entry.mods;
         report_ff.slots    <= slots_in;
         report_ff.rollover <= ovf_in;
      end
   end

endmodule

/* rtl/nkro_bitmap_to_six_key_report.sv */
// ----------------------------------------------------------------------------
// nkro_bitmap_to_six_key_report
// Turns an NKRO key bitmap, one byte per request, into a boot keyboard report.
// ----------------------------------------------------------------------------
// Push bitmap bytes in order from byte 0; the request flagged last closes the
// report and supplies the modifier byte. One byte is taken per clock while the
// queue is not full: the front tags each byte with its index, a four-entry
// queue decouples it from the slot collector, which scans the eight bits of a
// byte combinationally, and a one-entry output register holds the report.
// With nothing stalled, the last byte passes through the queue and the report
// is then registered into the output register, from which it can be popped.
// The input keeps accepting while a report waits to be popped, until the next
// last byte reaches the collector and the queue fills behind it. Usage 0 is
// never a key, bytes past the 32-byte bitmap are ignored, and a seventh key
// sets every slot to the rollover code 0x01 with rollover_flag high.
module nkro_bitmap_to_six_key_report (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_bitmap_byte,
   input  logic [7:0] req_modifier_bits,
   input  logic       req_last_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_modifiers,
   output logic [7:0] rsp_slot0,
   output logic [7:0] rsp_slot1,
   output logic [7:0] rsp_slot2,
   output logic [7:0] rsp_slot3,
   output logic [7:0] rsp_slot4,
   output logic [7:0] rsp_slot5,
   output logic       rsp_rollover_flag
);

   nbsk_pkg::enq_type     enq;
   logic                  q_full;
   logic                  deq_valid;
   nbsk_pkg::entry_type   deq_entry;
   logic                  deq_pop;
   nbsk_pkg::report_type  report;

   nbsk_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_bitmap_byte   (req_bitmap_byte),
      .req_modifier_bits (req_modifier_bits),
      .req_last_byte     (req_last_byte),
      .q_full            (q_full),
      .enq               (enq)
   );

   nbsk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq       (enq),
      .q_full    (q_full),
      .deq_valid (deq_valid),
      .deq_entry (deq_entry),
      .deq_pop   (deq_pop)
   );

   nbsk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (deq_valid),
      .deq_entry (deq_entry),
      .deq_pop   (deq_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .report    (report)
   );

   assign rsp_out_modifiers = report.mods;
   assign rsp_slot0         = report.slots[0];
   assign rsp_slot1         = report.slots[1];
   assign rsp_slot2         = report.slots[2];
   assign rsp_slot3         = report.slots[3];
   assign rsp_slot4         = report.slots[4];
   assign rsp_slot5         = report.slots[5];
   assign rsp_rollover_flag = report.rollover;

   // queue is drained by reset
   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("full after reset");

   a_rollover_code: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_rollover_flag) |-> (rsp_slot0 == nbsk_pkg::ROLLOVER_CODE))
      else $error("rollover report without rollover code");

   // slots 0 and 1 are filled in ascending order with no gap
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_rollover_flag && rsp_slot1 != 8'h00)
         |-> (rsp_slot0 != 8'h00 && rsp_slot0 < rsp_slot1))
      else $error("key slots out of order");

endmodule
